@@ hw/rtl/lpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page cache directory package
// Types, widths and controller commands that the directory modules share.
// ----------------------------------------------------------------------------
package lpcd_pkg;

	// Directory geometry.
	localparam int CAPACITY = 8;
	localparam int PAGE_W   = 20;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int RANK_W   = SLOT_W;

	// The least recent entry of a full directory carries this rank.
	localparam int RANK_OLDEST = CAPACITY - 1;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [RANK_W-1:0] rank_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the requested page
		logic lookup;  // compare tags and choose the target slot
		logic update;  // apply the recency update and present the result
	} lpcd_cmd_t;

endpackage

@@ hw/rtl/lpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// LRU page cache directory controller
// Sequences each request through the lookup and update steps and drives
// the busy flag and the result strobe.
// ----------------------------------------------------------------------------
module lpcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output lpcd_pkg::lpcd_cmd_t cmd
);
	import lpcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// State register with the busy flag and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOKUP;
						busy_q  <= 1'b1;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Datapath commands decoded from the state.
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.update = (state_q == ST_UPDATE);
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ hw/rtl/lpcd_datapath.sv @@
// ----------------------------------------------------------------------------
// LRU page cache directory datapath
// Holds tags, valid marks and recency ranks, compares all tags in parallel
// and applies the least-recently-used update.
// ----------------------------------------------------------------------------
module lpcd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lpcd_pkg::lpcd_cmd_t cmd,
	input  lpcd_pkg::page_t     page_number,
	output logic                hit,
	output lpcd_pkg::slot_t     slot,
	output logic                evicted,
	output lpcd_pkg::page_t     evicted_page
);
	import lpcd_pkg::*;

	// Directory state.
	page_t                tags_q [CAPACITY];
	logic  [CAPACITY-1:0] valid_q;
	rank_t                rank_q [CAPACITY];

	// Request and lookup results.
	page_t page_q;
	logic  hit_q;
	slot_t target_q;
	rank_t hit_rank_q;
	logic  evict_q;
	page_t victim_page_q;

	// Result registers.
	logic  res_hit_q;
	slot_t res_slot_q;
	logic  res_evicted_q;
	page_t res_page_q;

	// Lookup: first matching slot, first free slot and the oldest valid slot.
	logic  found;
	slot_t found_idx;
	logic  has_free;
	slot_t free_idx;
	slot_t victim_idx;

	always_comb begin
		found      = 1'b0;
		found_idx  = '0;
		has_free   = 1'b0;
		free_idx   = '0;
		victim_idx = '0;
		// Scan downward so that the lowest-numbered candidate wins.
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (valid_q[i] && (tags_q[i] == page_q)) begin
				found     = 1'b1;
				found_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if (valid_q[i] && (rank_q[i] == RANK_W'(RANK_OLDEST))) begin
				victim_idx = SLOT_W'(i);
			end
		end
	end

	// Request capture and lookup registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= page_number;
		end
		if (cmd.lookup) begin
			hit_q         <= found;
			hit_rank_q    <= rank_q[found_idx];
			evict_q       <= !found && !has_free;
			victim_page_q <= tags_q[victim_idx];
			if (found) begin
				target_q <= found_idx;
			end else if (has_free) begin
				target_q <= free_idx;
			end else begin
				target_q <= victim_idx;
			end
		end
	end

	// Valid marks and recency ranks; the target becomes most recent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (target_q == SLOT_W'(i)) begin
					rank_q[i]  <= '0;
					valid_q[i] <= 1'b1;
				end else if (valid_q[i] && (!hit_q || (rank_q[i] < hit_rank_q))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	// Tag store; only a miss writes the new page.
	always_ff @(posedge clk) begin
		if (cmd.update && !hit_q) begin
			tags_q[target_q] <= page_q;
		end
	end

	// Result registers, shown during the strobe cycle.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_hit_q     <= hit_q;
			res_slot_q    <= target_q;
			res_evicted_q <= evict_q;
			res_page_q    <= evict_q ? victim_page_q : '0;
		end
	end

	assign hit          = res_hit_q;
	assign slot         = res_slot_q;
	assign evicted      = res_evicted_q;
	assign evicted_page = res_page_q;

endmodule

@@ hw/rtl/lru_page_cache_directory.sv @@
// ----------------------------------------------------------------------------
// LRU page cache directory
// Fully associative directory of eight page slots with least-recently-used
// replacement.
// ----------------------------------------------------------------------------
// Usage: a request is transferred at a rising edge with start high and busy
// low; page_number is sampled at that edge. Busy then stays high through the
// parallel tag compare and slot choice and the rank, tag and valid update.
// The result (hit, slot, evicted, evicted_page) is shown with done high for
// exactly one cycle, the first cycle in which busy is low again. Note that
// evicted_page reads zero unless evicted is set. The receiver cannot stall;
// it must take the result in that cycle. A new request may be started in the
// same cycle as done, but none is taken while busy is high, so each request
// passes through the idle state, in which it is transferred, and the lookup
// and update steps of the controller.
// Reset clears all valid marks and ranks at once, so the directory is empty
// and ready for a request as soon as reset is released.
// ----------------------------------------------------------------------------
module lru_page_cache_directory (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lpcd_pkg::page_t page_number,
	output logic            done,
	output logic            hit,
	output lpcd_pkg::slot_t slot,
	output logic            evicted,
	output lpcd_pkg::page_t evicted_page
);
	import lpcd_pkg::*;

	lpcd_cmd_t cmd;

	// Request sequencing.
	lpcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Directory storage and lookup.
	lpcd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.page_number  (page_number),
		.hit          (hit),
		.slot         (slot),
		.evicted      (evicted),
		.evicted_page (evicted_page)
	);

endmodule
